// ===== src/spl_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, widths and constants for the stereo peak limiter.
package spl_pkg;

   localparam int SAMPLE_BITS = 16;
   localparam int FRAC_BITS   = 24;
   localparam int LEVEL_W     = FRAC_BITS + 1;
   localparam int COEF_W      = FRAC_BITS;
   localparam int MAG_SHIFT   = FRAC_BITS - (SAMPLE_BITS - 1);
   localparam int MUL_A_W     = LEVEL_W + 1;
   localparam int MUL_B_W     = LEVEL_W;
   localparam int PROD_W      = MUL_A_W + MUL_B_W + 1;
   localparam int RND_W       = PROD_W - FRAC_BITS;
   localparam int CSR_IDX_W   = 2;
   localparam int CSR_DATA_W  = LEVEL_W;

   localparam logic [CSR_IDX_W-1:0] CSR_ENABLE    = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_THRESHOLD = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_ATTACK    = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_RELEASE   = 2'd3;

   localparam logic [LEVEL_W-1:0]     THRESHOLD_RESET = 25'd12581134;
   localparam logic [COEF_W-1:0]      ATTACK_RESET    = 24'd16431300;
   localparam logic [COEF_W-1:0]      RELEASE_RESET   = 24'd16770226;
   localparam logic [LEVEL_W-1:0]     GAIN_ONE        = 25'h100_0000;
   localparam logic [SAMPLE_BITS-1:0] SAMPLE_MAX      = 16'h7fff;
   localparam logic [SAMPLE_BITS-1:0] SAMPLE_MIN      = 16'h8000;

   typedef struct packed {
      logic signed [SAMPLE_BITS-1:0] left_in;
      logic signed [SAMPLE_BITS-1:0] right_in;
   } frame_in_type;

   typedef struct packed {
      logic signed [SAMPLE_BITS-1:0] left_out;
      logic signed [SAMPLE_BITS-1:0] right_out;
   } frame_out_type;

endpackage

// ===== src/spl_serial_mul.sv =====
`timescale 1ns / 1ps
// Bit-serial signed by unsigned shift-add multiplier, one multiplier bit per cycle.
module spl_serial_mul #(
   parameter int A_W = 26,
   parameter int B_W = 25
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [A_W-1:0]   mcand,
   input  logic [B_W-1:0]   mplier,
   output logic             done,
   output logic [A_W+B_W:0] product
);

   localparam int CNT_W = $clog2(B_W);

   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [A_W-1:0]   mcand_ff, mcand_in;
   logic [A_W:0]     hi_ff, hi_in;
   logic [B_W-1:0]   lo_ff, lo_in;
   logic [A_W:0]     sum;

   always_comb begin
      sum      = hi_ff + (lo_ff[0] ? {mcand_ff[A_W-1], mcand_ff} : {(A_W+1){1'b0}});
      busy_in  = busy_ff;
      done_in  = 1'b0;
      cnt_in   = cnt_ff;
      mcand_in = mcand_ff;
      hi_in    = hi_ff;
      lo_in    = lo_ff;
      if (start) begin
         busy_in  = 1'b1;
         cnt_in   = '0;
         mcand_in = mcand;
         hi_in    = '0;
         lo_in    = mplier;
      end else if (busy_ff) begin
         hi_in  = {sum[A_W], sum[A_W:1]};
         lo_in  = {sum[0], lo_ff[B_W-1:1]};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CNT_W'(B_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      mcand_ff <= mcand_in;
      hi_ff    <= hi_in;
      lo_ff    <= lo_in;
   end

   assign done    = done_ff;
   assign product = {hi_ff, lo_ff};

endmodule

// ===== src/spl_serial_div.sv =====
`timescale 1ns / 1ps
// Restoring divider that produces one quotient bit per cycle for a fractional quotient.
module spl_serial_div #(
   parameter int D_W = 25,
   parameter int Q_W = 24
) (
   input  logic           clock,
   input  logic           reset,
   input  logic           start,
   input  logic [D_W-1:0] num,
   input  logic [D_W-1:0] den,
   output logic           done,
   output logic [Q_W-1:0] quot
);

   localparam int CNT_W = $clog2(Q_W);

   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [D_W-1:0]   rem_ff, rem_in;
   logic [D_W-1:0]   den_ff, den_in;
   logic [Q_W-1:0]   quot_ff, quot_in;
   logic [D_W:0]     shifted;
   logic [D_W:0]     diff;
   logic             ge;

   always_comb begin
      shifted = {rem_ff, 1'b0};
      diff    = shifted - {1'b0, den_ff};
      ge      = shifted >= {1'b0, den_ff};
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      quot_in = quot_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rem_in  = num;
         den_in  = den;
         quot_in = '0;
      end else if (busy_ff) begin
         rem_in  = ge ? diff[D_W-1:0] : shifted[D_W-1:0];
         quot_in = {quot_ff[Q_W-2:0], ge};
         cnt_in  = cnt_ff + 1'b1;
         if (cnt_ff == CNT_W'(Q_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff  <= rem_in;
      den_ff  <= den_in;
      quot_ff <= quot_in;
   end

   assign done = done_ff;
   assign quot = quot_ff;

endmodule

// ===== src/stereo_peak_limiter_core.sv =====
`timescale 1ns / 1ps
// Top level of the stereo peak limiter: control sequencer, state and result register.
// With limiting enabled the bit-serial multiplier is used four times per frame, and the
// divider runs only when the envelope is above the threshold.
// A new frame can be taken in the cycle after the result is registered; disabled frames
// skip the multiplier and the divider and go straight to the done state.
// Synchronous reset restores the register defaults, zero envelope and unity gain.
module stereo_peak_limiter_core (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  spl_pkg::frame_in_type                req_data,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output spl_pkg::frame_out_type               rsp_data,
   input  logic                                 csr_we,
   input  logic [spl_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [spl_pkg::CSR_DATA_W-1:0]       csr_wdata
);

   import spl_pkg::*;

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_ENV   = 3'd1;
   localparam logic [2:0] ST_TGT   = 3'd2;
   localparam logic [2:0] ST_DIV   = 3'd3;
   localparam logic [2:0] ST_GAIN  = 3'd4;
   localparam logic [2:0] ST_LEFT  = 3'd5;
   localparam logic [2:0] ST_RIGHT = 3'd6;
   localparam logic [2:0] ST_DONE  = 3'd7;

   logic [2:0]             state_ff, state_in;
   logic                   enable_ff, enable_in;
   logic [LEVEL_W-1:0]     threshold_ff, threshold_in;
   logic [COEF_W-1:0]      attack_ff, attack_in;
   logic [COEF_W-1:0]      release_ff, release_in;
   logic [LEVEL_W-1:0]     envelope_ff, envelope_in;
   logic [LEVEL_W-1:0]     gain_ff, gain_in;
   logic [LEVEL_W-1:0]     target_ff, target_in;
   logic [LEVEL_W-1:0]     peak_ff, peak_in;
   logic [SAMPLE_BITS-1:0] left_ff, left_in;
   logic [SAMPLE_BITS-1:0] right_ff, right_in;
   logic [SAMPLE_BITS-1:0] left_res_ff, left_res_in;
   logic [SAMPLE_BITS-1:0] right_res_ff, right_res_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   frame_out_type          rsp_data_ff, rsp_data_in;
   logic                   mul_start_ff, mul_start_in;
   logic                   div_start_ff, div_start_in;

   logic                   req_fire;
   logic                   rsp_load;
   logic [SAMPLE_BITS-1:0] mag_left;
   logic [SAMPLE_BITS-1:0] mag_right;
   logic [SAMPLE_BITS-1:0] mag_peak;
   logic [MUL_A_W-1:0]     mul_mcand;
   logic [MUL_B_W-1:0]     mul_mplier;
   logic                   mul_done;
   logic [PROD_W-1:0]      mul_product;
   logic                   div_done;
   logic [COEF_W-1:0]      div_quot;
   logic [RND_W-1:0]       rnd;
   logic [RND_W-1:0]       pole_sum;
   logic [LEVEL_W-1:0]     pole_tgt;
   logic                   rnd_fits;
   logic [SAMPLE_BITS-1:0] rnd_sat;

   assign req_stall = (state_ff != ST_IDLE);
   assign req_fire  = req_valid && !req_stall;
   assign rsp_load  = (state_ff == ST_DONE) && (!rsp_valid_ff || !rsp_stall);

   always_comb begin
      mag_left  = req_data.left_in[SAMPLE_BITS-1] ? (~req_data.left_in + 1'b1)
                                                   : req_data.left_in;
      mag_right = req_data.right_in[SAMPLE_BITS-1] ? (~req_data.right_in + 1'b1)
                                                    : req_data.right_in;
      mag_peak  = (mag_left > mag_right) ? mag_left : mag_right;
   end

   always_comb begin
      mul_mcand  = '0;
      mul_mplier = '0;
      case (state_ff)
         ST_ENV: begin
            mul_mcand  = {1'b0, envelope_ff} - {1'b0, peak_ff};
            mul_mplier = {1'b0, (peak_ff > envelope_ff) ? attack_ff : release_ff};
         end
         ST_GAIN: begin
            mul_mcand  = {1'b0, gain_ff} - {1'b0, target_ff};
            mul_mplier = {1'b0, (target_ff < gain_ff) ? attack_ff : release_ff};
         end
         ST_LEFT: begin
            mul_mcand  = {{(MUL_A_W-SAMPLE_BITS){left_ff[SAMPLE_BITS-1]}}, left_ff};
            mul_mplier = gain_ff;
         end
         ST_RIGHT: begin
            mul_mcand  = {{(MUL_A_W-SAMPLE_BITS){right_ff[SAMPLE_BITS-1]}}, right_ff};
            mul_mplier = gain_ff;
         end
         default: begin
            mul_mcand  = '0;
            mul_mplier = '0;
         end
      endcase
   end

   spl_serial_mul #(
      .A_W (MUL_A_W),
      .B_W (MUL_B_W)
   ) u_mul (
      .clock   (clock),
      .reset   (reset),
      .start   (mul_start_ff),
      .mcand   (mul_mcand),
      .mplier  (mul_mplier),
      .done    (mul_done),
      .product (mul_product)
   );

   spl_serial_div #(
      .D_W (LEVEL_W),
      .Q_W (COEF_W)
   ) u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start_ff),
      .num   (threshold_ff),
      .den   (envelope_ff),
      .done  (div_done),
      .quot  (div_quot)
   );

   // Rounding adds one half, which reduces to adding the bit just below the binary point.
   always_comb begin
      rnd      = mul_product[PROD_W-1:FRAC_BITS]
                 + {{(RND_W-1){1'b0}}, mul_product[FRAC_BITS-1]};
      pole_tgt = (state_ff == ST_ENV) ? peak_ff : target_ff;
      pole_sum = rnd + {{(RND_W-LEVEL_W){1'b0}}, pole_tgt};
      rnd_fits = (rnd[RND_W-1:SAMPLE_BITS-1] == '0) || (rnd[RND_W-1:SAMPLE_BITS-1] == '1);
      rnd_sat  = rnd_fits ? rnd[SAMPLE_BITS-1:0]
                          : (rnd[RND_W-1] ? SAMPLE_MIN : SAMPLE_MAX);
   end

   always_comb begin
      enable_in    = enable_ff;
      threshold_in = threshold_ff;
      attack_in    = attack_ff;
      release_in   = release_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_ENABLE:    enable_in    = csr_wdata[0];
            CSR_THRESHOLD: threshold_in = csr_wdata[LEVEL_W-1:0];
            CSR_ATTACK:    attack_in    = csr_wdata[COEF_W-1:0];
            CSR_RELEASE:   release_in   = csr_wdata[COEF_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      state_in     = state_ff;
      envelope_in  = envelope_ff;
      gain_in      = gain_ff;
      target_in    = target_ff;
      peak_in      = peak_ff;
      left_in      = left_ff;
      right_in     = right_ff;
      left_res_in  = left_res_ff;
      right_res_in = right_res_ff;
      mul_start_in = 1'b0;
      div_start_in = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               left_in  = req_data.left_in;
               right_in = req_data.right_in;
               peak_in  = {mag_peak, {MAG_SHIFT{1'b0}}};
               if (enable_ff) begin
                  state_in     = ST_ENV;
                  mul_start_in = 1'b1;
               end else begin
                  left_res_in  = req_data.left_in;
                  right_res_in = req_data.right_in;
                  state_in     = ST_DONE;
               end
            end
         end
         ST_ENV: begin
            if (mul_done) begin
               envelope_in = pole_sum[LEVEL_W-1:0];
               state_in    = ST_TGT;
            end
         end
         ST_TGT: begin
            if (envelope_ff > threshold_ff) begin
               state_in     = ST_DIV;
               div_start_in = 1'b1;
            end else begin
               target_in    = GAIN_ONE;
               state_in     = ST_GAIN;
               mul_start_in = 1'b1;
            end
         end
         ST_DIV: begin
            if (div_done) begin
               target_in    = {1'b0, div_quot};
               state_in     = ST_GAIN;
               mul_start_in = 1'b1;
            end
         end
         ST_GAIN: begin
            if (mul_done) begin
               gain_in      = pole_sum[LEVEL_W-1:0];
               state_in     = ST_LEFT;
               mul_start_in = 1'b1;
            end
         end
         ST_LEFT: begin
            if (mul_done) begin
               left_res_in  = rnd_sat;
               state_in     = ST_RIGHT;
               mul_start_in = 1'b1;
            end
         end
         ST_RIGHT: begin
            if (mul_done) begin
               right_res_in = rnd_sat;
               state_in     = ST_DONE;
            end
         end
         ST_DONE: begin
            if (rsp_load) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff;
      if (rsp_load) begin
         rsp_data_in.left_out  = left_res_ff;
         rsp_data_in.right_out = right_res_ff;
         rsp_valid_in          = 1'b1;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         enable_ff    <= 1'b1;
         threshold_ff <= THRESHOLD_RESET;
         attack_ff    <= ATTACK_RESET;
         release_ff   <= RELEASE_RESET;
         envelope_ff  <= '0;
         gain_ff      <= GAIN_ONE;
         rsp_valid_ff <= 1'b0;
         mul_start_ff <= 1'b0;
         div_start_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         enable_ff    <= enable_in;
         threshold_ff <= threshold_in;
         attack_ff    <= attack_in;
         release_ff   <= release_in;
         envelope_ff  <= envelope_in;
         gain_ff      <= gain_in;
         rsp_valid_ff <= rsp_valid_in;
         mul_start_ff <= mul_start_in;
         div_start_ff <= div_start_in;
      end
   end

   always_ff @(posedge clock) begin
      target_ff    <= target_in;
      peak_ff      <= peak_in;
      left_ff      <= left_in;
      right_ff     <= right_in;
      left_res_ff  <= left_res_in;
      right_res_ff <= right_res_in;
      rsp_data_ff  <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// ===== src/spl_checker.sv =====
`timescale 1ns / 1ps
// Port-level checker for the stereo peak limiter and the bind that attaches it.
module spl_checker (
   input logic clock,
   input logic reset,
   input logic req_valid,
   input logic req_stall,
   input logic rsp_valid,
   input logic rsp_stall
);

   logic [1:0] pending_ff, pending_in;
   logic       req_fire;
   logic       rsp_fire;

   assign req_fire = req_valid && !req_stall;
   assign rsp_fire = rsp_valid && !rsp_stall;

   always_comb begin
      pending_in = pending_ff;
      if (req_fire && !rsp_fire) begin
         pending_in = pending_ff + 1'b1;
      end else if (rsp_fire && !req_fire) begin
         pending_in = pending_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= '0;
      end else begin
         pending_ff <= pending_in;
      end
   end

   a_no_invented_beat: assert property (@(posedge clock) disable iff (reset)
      rsp_fire |-> pending_ff != 2'd0)
      else $error("result beat delivered with no frame outstanding");

   a_pending_bounded: assert property (@(posedge clock) disable iff (reset)
      pending_ff != 2'd3)
      else $error("more than two frames outstanding");

   a_full_stalls: assert property (@(posedge clock) disable iff (reset)
      pending_ff == 2'd2 |-> req_stall)
      else $error("input taken while a result waits and a frame is in flight");

   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> req_stall)
      else $error("input not stalled after a frame was taken");

   a_valid_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("result valid dropped while stalled");

endmodule

bind stereo_peak_limiter_core spl_checker u_spl_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall)
);
